>>> src/klbei_pkg.sv
// Shared types, constants and helpers for the key lower-bound to entry-index block.
// No dependencies. Used by klbei_ctrl, klbei_dp and key_lower_bound_to_entry_index_core.
package klbei_pkg;

  // Grid limits and field widths
  localparam int unsigned MAX_RANK    = 4;
  localparam int unsigned DIGIT_BYTES = 4;
  localparam int unsigned RANK_W      = 3;
  localparam int unsigned EXTENT_W    = 16;
  localparam int unsigned DIGIT_W     = 32;
  localparam int unsigned ENTRY_W     = 64;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANK     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_3 = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // take the input beat
    logic pad_shift;  // shift a zero byte into a partial digit
    logic mul;        // product register <= accumulator * extent
    logic add;        // accumulator <= product + digit term
    logic tot_init;   // start the entry-count product
    logic tot_step;   // multiply in one more extent
    logic load_out;   // load the result register and clear the key
    logic use_total;  // result is the entry count (empty upper key)
  } klbei_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic dim_lt_rank;  // digits still to complete
    logic part_zero;    // no partial digit bytes held
    logic part_three;   // next byte completes a digit
    logic key_empty;    // no byte taken and none overlong
    logic tot_done;     // entry count complete
    logic out_free;     // result register can be loaded this cycle
  } klbei_sts_t;

  // Rank in use: zero reads as one, above the limit reads as the limit
  function automatic logic [RANK_W-1:0] used_rank(input logic [RANK_W-1:0] rank);
    logic [RANK_W-1:0] r;
    r = rank;
    if (r == '0) r = RANK_W'(1);
    if (r > RANK_W'(MAX_RANK)) r = RANK_W'(MAX_RANK);
    return r;
  endfunction

endpackage

>>> src/klbei_dp.sv
// Datapath: configuration registers, key assembly, shared 64x16 multiplier,
// entry-count product and result register. Depends on klbei_pkg.
module klbei_dp
  import klbei_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [7:0]            key_byte_i,
  input  logic                  byte_present_i,
  input  logic                  out_stall_i,
  input  klbei_cmd_t            cmd_i,
  output klbei_sts_t            sts_o,
  output logic                  out_valid_o,
  output logic [ENTRY_W-1:0]    entry_index_o
);

  logic [RANK_W-1:0]   rank_q;
  logic [EXTENT_W-1:0] ext_q [MAX_RANK];

  logic [POS_W-1:0]    pos_q;
  logic [DIGIT_W-1:0]  idx_q;
  logic [ENTRY_W-1:0]  acc_q;
  logic [ENTRY_W-1:0]  prod_q;
  logic [ENTRY_W-1:0]  tot_q;
  logic [RANK_W-1:0]   dim_q;
  logic [RANK_W-1:0]   tcnt_q;
  logic                clamp_q;
  logic                over_q;
  logic [ENTRY_W-1:0]  out_q;
  logic                out_valid_q;

  logic [RANK_W-1:0]           rank_w;
  logic                        dim_lt_w;
  logic [EXTENT_W-1:0]         ext_w;
  logic [ENTRY_W-1:0]          mul_a_w;
  logic [ENTRY_W+EXTENT_W-1:0] mul_w;
  logic                        ge_w;
  logic [ENTRY_W-1:0]          term_w;
  logic [ENTRY_W-1:0]          adj_w;

  assign rank_w   = used_rank(rank_q);
  assign dim_lt_w = dim_q < rank_w;

  // Shared multiplier: accumulator for digits, entry count otherwise
  assign ext_w   = cmd_i.tot_step ? ext_q[tcnt_q[1:0]] : ext_q[dim_q[1:0]];
  assign mul_a_w = cmd_i.tot_step ? tot_q : acc_q;
  assign mul_w   = mul_a_w * ext_w;

  // Digit term: zero once clamped; else index below extent adds itself, at or above adds the extent
  assign ge_w   = idx_q >= {{(DIGIT_W-EXTENT_W){1'b0}}, ext_w};
  assign term_w = clamp_q ? '0 :
                  ge_w    ? {{(ENTRY_W-EXTENT_W){1'b0}}, ext_w} :
                            {{(ENTRY_W-DIGIT_W){1'b0}}, idx_q};

  // Overlong key moves one past, but never beyond the entry count
  assign adj_w = (over_q && (acc_q < tot_q)) ? acc_q + ENTRY_W'(1) : acc_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= RANK_W'(1);
      for (int i = 0; i < MAX_RANK; i++) ext_q[i] <= EXTENT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_RANK:     rank_q   <= cfg_data_i[RANK_W-1:0];
        REG_EXTENT_0: ext_q[0] <= cfg_data_i;
        REG_EXTENT_1: ext_q[1] <= cfg_data_i;
        REG_EXTENT_2: ext_q[2] <= cfg_data_i;
        REG_EXTENT_3: ext_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Key assembly and accumulation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      idx_q   <= '0;
      acc_q   <= '0;
      prod_q  <= '0;
      tot_q   <= '0;
      dim_q   <= '0;
      tcnt_q  <= '0;
      clamp_q <= 1'b0;
      over_q  <= 1'b0;
    end else begin
      if (cmd_i.accept && byte_present_i) begin
        if (dim_lt_w) begin
          idx_q <= {idx_q[DIGIT_W-9:0], key_byte_i};
          pos_q <= pos_q + POS_W'(1);
        end else begin
          over_q <= 1'b1;
        end
      end
      if (cmd_i.pad_shift) begin
        idx_q <= {idx_q[DIGIT_W-9:0], 8'h00};
        pos_q <= pos_q + POS_W'(1);
      end
      if (cmd_i.mul) prod_q <= mul_w[ENTRY_W-1:0];
      if (cmd_i.add) begin
        acc_q   <= prod_q + term_w;
        clamp_q <= clamp_q | ge_w;
        dim_q   <= dim_q + RANK_W'(1);
        idx_q   <= '0;
      end
      if (cmd_i.tot_init) begin
        tot_q  <= ENTRY_W'(1);
        tcnt_q <= '0;
      end
      if (cmd_i.tot_step) begin
        tot_q  <= mul_w[ENTRY_W-1:0];
        tcnt_q <= tcnt_q + RANK_W'(1);
      end
      // key done: back to the cleared state
      if (cmd_i.load_out) begin
        pos_q   <= '0;
        idx_q   <= '0;
        acc_q   <= '0;
        dim_q   <= '0;
        clamp_q <= 1'b0;
        over_q  <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) out_q <= cmd_i.use_total ? tot_q : adj_w;
  end

  assign sts_o.dim_lt_rank = dim_lt_w;
  assign sts_o.part_zero   = pos_q[1:0] == 2'd0;
  assign sts_o.part_three  = pos_q[1:0] == 2'd3;
  assign sts_o.key_empty   = (pos_q == '0) && !over_q;
  assign sts_o.tot_done    = tcnt_q == rank_w;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign entry_index_o = out_q;

endmodule

>>> src/klbei_ctrl.sv
// Controller state machine: sequences byte intake, digit multiply/add, padding,
// entry-count product and result hand-off. Depends on klbei_pkg.
module klbei_ctrl
  import klbei_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       byte_present_i,
  input  logic       last_byte_i,
  input  logic       is_upper_i,
  output logic       in_stall_o,
  input  klbei_sts_t sts_i,
  output klbei_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_TOT  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q, state_d;
  logic       fin_q, fin_d;
  logic       empty_q, empty_d;
  logic       take_w;

  assign take_w = in_valid_i && (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    empty_d = empty_q;
    cmd_o   = '0;
    cmd_o.use_total = empty_q;
    case (state_q)
      S_IDLE: begin
        if (take_w) begin
          cmd_o.accept = 1'b1;
          if (byte_present_i && sts_i.dim_lt_rank && sts_i.part_three) begin
            state_d = S_MUL;
            fin_d   = last_byte_i;
          end else if (last_byte_i) begin
            state_d = S_FIN;
            fin_d   = 1'b1;
            empty_d = !byte_present_i && sts_i.key_empty && is_upper_i;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = fin_q ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (!empty_q && sts_i.dim_lt_rank) begin
          if (!sts_i.part_zero) begin
            cmd_o.pad_shift = 1'b1;
          end else begin
            state_d = S_MUL;
          end
        end else begin
          cmd_o.tot_init = 1'b1;
          state_d        = S_TOT;
        end
      end
      S_TOT: begin
        if (sts_i.tot_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o.tot_step = 1'b1;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
          fin_d          = 1'b0;
          empty_d        = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
        fin_d   = 1'b0;
        empty_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fin_q   <= 1'b0;
      empty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      empty_q <= empty_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

>>> src/key_lower_bound_to_entry_index_core.sv
// Key lower bound to row-major entry index: top level.
// Depends on klbei_pkg, klbei_ctrl and klbei_dp.
//
// Input channel (in_valid_i / in_stall_o): one key byte per beat, most
//   significant byte of dimension zero first. byte_present_i = 0 with last_byte_i
//   ends a key without a byte (empty key when first); is_upper_i is sampled on
//   the last beat. A beat without byte and without last is dropped.
// Output channel (out_valid_o / out_stall_i): one 64-bit entry index per key from
//   a result register; the next key's bytes are taken while a result waits there.
// Configuration: rank and extents via cfg_we_i, cfg_index_i and cfg_data_i between
//   keys; indexes beyond the list are ignored.
// Sequence: a byte that does not complete a digit is taken alone; one that completes
//   a digit is followed by a multiply, then an add on the shared 64x16 multiplier. After
//   the last byte: zero-byte padding of a partial digit, a multiply and an add per digit
//   still missing, the entry-count product one extent per step, then the result load.
// A stalled receiver holding the result register makes the block wait before
//   loading it, taking no byte meanwhile.
// Reset: rank and extents return to 1, the key state is cleared, no result pends.
module key_lower_bound_to_entry_index_core
  import klbei_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            key_byte_i,
  input  logic                  byte_present_i,
  input  logic                  last_byte_i,
  input  logic                  is_upper_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ENTRY_W-1:0]    entry_index_o
);

  klbei_cmd_t cmd;
  klbei_sts_t sts;

  klbei_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .byte_present_i (byte_present_i),
    .last_byte_i    (last_byte_i),
    .is_upper_i     (is_upper_i),
    .in_stall_o     (in_stall_o),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  klbei_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .key_byte_i     (key_byte_i),
    .byte_present_i (byte_present_i),
    .out_stall_i    (out_stall_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .entry_index_o  (entry_index_o)
  );

endmodule
